// ----- src/radio_display_link_receiver_core_macros.svh -----
// Assertion helpers for the display link receiver.
`ifndef RADIO_DISPLAY_LINK_RECEIVER_CORE_MACROS_SVH
`define RADIO_DISPLAY_LINK_RECEIVER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Condition that must hold at every edge out of reset.
`define RDL_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Overlapping implication checked at every edge out of reset.
`define RDL_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`else

`define RDL_ASSERT_ALWAYS(lbl, cond, msg)
`define RDL_ASSERT_IMPLY(lbl, ante, cons, msg)

`endif

`endif

// ----- src/rdl_pkg.sv -----
package rdl_pkg;

    localparam int unsigned FRAME_LEN      = 10;
    localparam int unsigned POS_W          = 4;
    localparam int unsigned TEXT_CHARS_MAX = 8;
    localparam int unsigned TEXT_CHARS_DEF = 8;
    localparam int unsigned CHAR_W         = 7;

    localparam logic [23:0] TICK_MAX = 24'hFF_FFFF;

    localparam logic [15:0] HANDSHAKE_DELAY_RST = 16'd100;
    localparam logic [23:0] TIMEOUT_RST         = 24'd1000000;

    localparam logic CFG_HANDSHAKE_DELAY = 1'b0;
    localparam logic CFG_TIMEOUT         = 1'b1;

    localparam logic [2:0] CMD_TICK     = 3'd0;
    localparam logic [2:0] CMD_MRQ      = 3'd1;
    localparam logic [2:0] CMD_ADDR     = 3'd2;
    localparam logic [2:0] CMD_DATA     = 3'd3;
    localparam logic [2:0] CMD_BUS_ERR  = 3'd4;

    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_FRAME   = 2'd1;
    localparam logic [1:0] KIND_TIMEOUT = 2'd2;
    localparam logic [1:0] KIND_BUS_ERR = 2'd3;

    typedef struct packed {
        logic [2:0] cmd;
        logic       mrq_level;
        logic [7:0] data_byte;
    } evt_word_t;

    typedef struct packed {
        logic [1:0]                         result_kind;
        logic                               sda_pull_low;
        logic                               capture_enabled;
        logic [5:0]                         indicator_flags;
        logic [4:0]                         audio_flags;
        logic [TEXT_CHARS_MAX*CHAR_W-1:0]   text_chars;
    } res_word_t;

endpackage

// ----- src/radio_display_link_receiver_core.sv -----
// Display link receiver: MRQ handshake sequencer plus I2C slave byte capture.
// Takes one event word per clock when ready (tick, MRQ change, address match,
// data byte, bus error) and returns exactly one result word per event in the
// cycle after acceptance, through a single output register; a new event is
// accepted whenever that register is empty or being taken in the same cycle.
// The ten-byte frame store is held in flip-flops, decoded in the same cycle
// as the ending MRQ rising edge, and cleared at once after each transaction.
// Configuration writes are applied at the edge where cfg_we is high.
`include "radio_display_link_receiver_core_macros.svh"

module radio_display_link_receiver_core #(
    parameter int unsigned TEXT_CHARS = rdl_pkg::TEXT_CHARS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,

    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [23:0]         cfg_data,

    input  logic                evt_valid,
    output logic                evt_ready,
    input  rdl_pkg::evt_word_t  evt_word,

    output logic                res_valid,
    input  logic                res_ready,
    output rdl_pkg::res_word_t  res_word
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_DELAY_LOW,
        PH_WAIT_HIGH,
        PH_DELAY_RELEASE,
        PH_WAIT_END
    } phase_t;

    logic [15:0] delay_reg;
    logic [23:0] timeout_reg;

    phase_t      phase_reg, phase_next;
    logic [23:0] tick_reg, tick_next, tick_inc;
    logic        mrq_reg, mrq_next;
    logic        sda_reg, sda_next;
    logic        cap_reg, cap_next;
    logic [rdl_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [7:0]  frame_reg [rdl_pkg::FRAME_LEN];

    logic        store_we;
    logic        store_clr;
    logic [23:0] delay_ext;

    logic               res_valid_reg;
    rdl_pkg::res_word_t res_reg, res_next;

    logic accept;

    assign evt_ready = !res_valid_reg || res_ready;
    assign accept    = evt_valid && evt_ready;
    assign res_valid = res_valid_reg;
    assign res_word  = res_reg;
    assign delay_ext = {8'd0, delay_reg};
    assign tick_inc  = (tick_reg == rdl_pkg::TICK_MAX) ? tick_reg : tick_reg + 24'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg   <= rdl_pkg::HANDSHAKE_DELAY_RST;
            timeout_reg <= rdl_pkg::TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rdl_pkg::CFG_HANDSHAKE_DELAY: delay_reg   <= cfg_data[15:0];
                rdl_pkg::CFG_TIMEOUT:         timeout_reg <= cfg_data;
                default:                      ;
            endcase
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        mrq_next   = mrq_reg;
        sda_next   = sda_reg;
        cap_next   = cap_reg;
        pos_next   = pos_reg;
        store_we   = 1'b0;
        store_clr  = 1'b0;
        res_next   = '0;

        unique case (evt_word.cmd)
            rdl_pkg::CMD_TICK:
            begin
                if (phase_reg != PH_IDLE && phase_reg != PH_WAIT_HIGH)
                begin
                    tick_next = tick_inc;
                    if (phase_reg == PH_DELAY_LOW && tick_inc >= delay_ext)
                    begin
                        sda_next   = 1'b1;
                        phase_next = PH_WAIT_HIGH;
                        if (mrq_reg)
                        begin
                            tick_next  = '0;
                            phase_next = PH_DELAY_RELEASE;
                            if (delay_reg == 16'd0)
                            begin
                                sda_next   = 1'b0;
                                cap_next   = 1'b1;
                                phase_next = PH_WAIT_END;
                            end
                        end
                    end
                    else if (phase_reg == PH_DELAY_RELEASE && tick_inc >= delay_ext)
                    begin
                        sda_next   = 1'b0;
                        cap_next   = 1'b1;
                        tick_next  = '0;
                        phase_next = PH_WAIT_END;
                    end
                    else if (phase_reg == PH_WAIT_END && tick_inc >= timeout_reg)
                    begin
                        cap_next             = 1'b0;
                        res_next.result_kind = rdl_pkg::KIND_TIMEOUT;
                        store_clr            = 1'b1;
                        tick_next            = '0;
                        phase_next           = PH_IDLE;
                    end
                end
            end
            rdl_pkg::CMD_MRQ:
            begin
                mrq_next = evt_word.mrq_level;
                if (evt_word.mrq_level != mrq_reg)
                begin
                    if (!evt_word.mrq_level)
                    begin
                        if (phase_reg == PH_IDLE)
                        begin
                            // level is now low, so a zero delay parks in wait-high
                            cap_next   = 1'b0;
                            tick_next  = '0;
                            phase_next = PH_DELAY_LOW;
                            if (delay_reg == 16'd0)
                            begin
                                sda_next   = 1'b1;
                                phase_next = PH_WAIT_HIGH;
                            end
                        end
                    end
                    else if (phase_reg == PH_WAIT_HIGH)
                    begin
                        tick_next  = '0;
                        phase_next = PH_DELAY_RELEASE;
                        if (delay_reg == 16'd0)
                        begin
                            sda_next   = 1'b0;
                            cap_next   = 1'b1;
                            phase_next = PH_WAIT_END;
                        end
                    end
                    else if (phase_reg == PH_WAIT_END)
                    begin
                        res_next.result_kind     = rdl_pkg::KIND_FRAME;
                        res_next.indicator_flags = {frame_reg[0][7:4], frame_reg[0][2:1]};
                        res_next.audio_flags     = frame_reg[1][7:3];
                        for (int i = 0; i < rdl_pkg::TEXT_CHARS_MAX; i++)
                        begin
                            if (i < TEXT_CHARS)
                            begin
                                res_next.text_chars[i*rdl_pkg::CHAR_W +: rdl_pkg::CHAR_W] =
                                    frame_reg[i+2][7:1];
                            end
                        end
                        store_clr  = 1'b1;
                        tick_next  = '0;
                        phase_next = PH_IDLE;
                    end
                end
            end
            rdl_pkg::CMD_ADDR:
            begin
                if (cap_reg)
                begin
                    pos_next = '0;
                end
            end
            rdl_pkg::CMD_DATA:
            begin
                if (cap_reg && pos_reg < rdl_pkg::POS_W'(rdl_pkg::FRAME_LEN))
                begin
                    store_we = 1'b1;
                    pos_next = pos_reg + rdl_pkg::POS_W'(1);
                end
            end
            rdl_pkg::CMD_BUS_ERR:
            begin
                if (cap_reg)
                begin
                    cap_next             = 1'b0;
                    res_next.result_kind = rdl_pkg::KIND_BUS_ERR;
                end
            end
            default: ;
        endcase

        res_next.sda_pull_low    = sda_next;
        res_next.capture_enabled = cap_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            tick_reg      <= '0;
            mrq_reg       <= 1'b1;
            sda_reg       <= 1'b0;
            cap_reg       <= 1'b1;
            pos_reg       <= '0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < rdl_pkg::FRAME_LEN; i++)
            begin
                frame_reg[i] <= '0;
            end
        end
        else
        begin
            res_valid_reg <= accept || (res_valid_reg && !res_ready);
            if (accept)
            begin
                phase_reg     <= phase_next;
                tick_reg      <= tick_next;
                mrq_reg       <= mrq_next;
                sda_reg       <= sda_next;
                cap_reg       <= cap_next;
                pos_reg       <= pos_next;
                if (store_clr)
                begin
                    for (int i = 0; i < rdl_pkg::FRAME_LEN; i++)
                    begin
                        frame_reg[i] <= '0;
                    end
                end
                else if (store_we)
                begin
                    frame_reg[pos_reg] <= evt_word.data_byte;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    `RDL_ASSERT_ALWAYS(a_sda_phase, sda_reg == (phase_reg == PH_WAIT_HIGH || phase_reg == PH_DELAY_RELEASE), "SDA pull-low out of step with handshake phase")
    `RDL_ASSERT_IMPLY(a_cap_off_hs, phase_reg == PH_DELAY_LOW || phase_reg == PH_WAIT_HIGH, !cap_reg, "capture on during first handshake half")
    `RDL_ASSERT_ALWAYS(a_pos_range, pos_reg <= rdl_pkg::POS_W'(rdl_pkg::FRAME_LEN), "byte index past frame end")
    `RDL_ASSERT_IMPLY(a_idle_tick, phase_reg == PH_IDLE, tick_reg == 24'd0, "tick count running while idle")
    `RDL_ASSERT_IMPLY(a_flags_frame, res_valid_reg && res_reg.result_kind != rdl_pkg::KIND_FRAME, res_reg.indicator_flags == 6'd0 && res_reg.audio_flags == 5'd0 && res_reg.text_chars == '0, "decode fields set on a non-frame word")

endmodule
